// File: src/fyse_pkg.sv
// ----------------------------------------------------------------------------
// Fisher-Yates shuffle engine package
// Shared widths, input mode codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package fyse_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RAND = 1'b1;

  typedef struct packed {
    logic load;
    logic idx_set;
    logic div_start;
    logic swap_rd;
    logic wr_j;
    logic wr_idx;
    logic emit_rd;
    logic k_clr;
    logic k_inc;
    logic len_clr;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic div_done;
    logic reject;
    logic idx_one;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

// File: src/fyse_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one load byte or one random word per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fyse_in_if
  import fyse_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] data_byte;
  logic              last_element;
  logic [WORD_W-1:0] rand_word;

  modport source (output valid, output mode, output data_byte, output last_element,
                  output rand_word, input ready);
  modport sink   (input valid, input mode, input data_byte, input last_element,
                  input rand_word, output ready);
endinterface

`default_nettype wire

// File: src/fyse_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one shuffled byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fyse_out_if
  import fyse_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// File: src/fyse_rem_div.sv
// ----------------------------------------------------------------------------
// Bounded draw remainder unit
// Restoring divider giving word mod range, one bit per cycle, plus the
// rejection test for an unbiased draw.
// ----------------------------------------------------------------------------
`default_nettype none

module fyse_rem_div
  import fyse_pkg::*;
#(
  parameter int LEN_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [LEN_W-1:0]  range,
  output      logic [LEN_W-1:0]  rem,
  output      logic              reject,
  output      logic              done
);

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [LEN_W:0]    trial;
  logic [LEN_W-1:0]  span;
  logic [WORD_W:0]   block_end;

  always_comb begin
    trial     = {rem_r, word_r[WORD_W-1]};
    word_nxt  = word_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      word_nxt = word;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      word_nxt = {word_r[WORD_W-2:0], word_r[WORD_W-1]};
      if (trial >= {1'b0, range}) begin
        rem_nxt = LEN_W'(trial - {1'b0, range});
      end else begin
        rem_nxt = LEN_W'(trial);
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // The word has rotated back to its original value once the division ends.
  // The draw is rejected when the block of range values holding the word
  // reaches or runs past the top of the 32-bit space.
  always_comb begin
    span      = range - rem_r;
    block_end = {1'b0, word_r} + {{(WORD_W + 1 - LEN_W){1'b0}}, span};
  end

  assign rem    = rem_r;
  assign reject = block_end[WORD_W];
  assign done   = done_r;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(WORD_W + 1) done_r)
    else $error("remainder unit did not finish on time");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r || done_r) |-> (rem_r < range))
    else $error("partial remainder reached the range");
`endif

endmodule

`default_nettype wire

// File: src/fyse_datapath.sv
// ----------------------------------------------------------------------------
// Shuffle datapath
// Byte buffer, length, swap index and emit counter, driven by controller
// commands; holds the remainder unit for the bounded draws.
// ----------------------------------------------------------------------------
`default_nettype none

module fyse_datapath
  import fyse_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output      sts_t              sts,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [WORD_W-1:0] rand_word,
  output      logic [BYTE_W-1:0] out_byte
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);

  logic [BYTE_W-1:0] buf_r [MAX_LEN];
  logic [BYTE_W-1:0] rd_a_r, rd_b_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0]  range;
  logic [LEN_W-1:0]  rem;
  logic [ADDR_W-1:0] j_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_a_en;
  logic [ADDR_W-1:0] rd_a_addr;
  logic              len_full;
  logic              div_reject;
  logic              div_done;

  assign len_full = (len_r == LEN_W'(MAX_LEN));
  assign range    = LEN_W'(idx_r) + LEN_W'(1);
  assign j_addr   = rem[ADDR_W-1:0];

  fyse_rem_div #(
    .LEN_W (LEN_W)
  ) u_rem_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .word   (rand_word),
    .range  (range),
    .rem    (rem),
    .reject (div_reject),
    .done   (div_done)
  );

  always_comb begin
    len_nxt = len_r;
    idx_nxt = idx_r;
    k_nxt   = k_r;
    if (cmd.len_clr) begin
      len_nxt = '0;
      idx_nxt = '0;
    end else begin
      if (cmd.load && !len_full) begin
        len_nxt = len_r + LEN_W'(1);
      end
      if (cmd.idx_set) begin
        idx_nxt = len_full ? ADDR_W'(MAX_LEN - 1) : len_r[ADDR_W-1:0];
      end else if (cmd.wr_idx) begin
        idx_nxt = idx_r - ADDR_W'(1);
      end
    end
    if (cmd.k_clr) begin
      k_nxt = '0;
    end else if (cmd.k_inc) begin
      k_nxt = k_r + ADDR_W'(1);
    end
  end

  always_comb begin
    wr_en     = (cmd.load && !len_full) || cmd.wr_j || cmd.wr_idx;
    wr_addr   = idx_r;
    wr_data   = rd_a_r;
    if (cmd.load) begin
      wr_addr = len_r[ADDR_W-1:0];
      wr_data = data_byte;
    end else if (cmd.wr_j) begin
      wr_addr = j_addr;
      wr_data = rd_b_r;
    end
    rd_a_en   = cmd.swap_rd || cmd.emit_rd;
    rd_a_addr = cmd.emit_rd ? k_r : j_addr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= buf_r[rd_a_addr];
    end
    if (cmd.swap_rd) begin
      rd_b_r <= buf_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      idx_r <= '0;
      k_r   <= '0;
    end else begin
      len_r <= len_nxt;
      idx_r <= idx_nxt;
      k_r   <= k_nxt;
    end
  end

  always_comb begin
    sts.len_zero  = (len_r == '0);
    sts.div_done  = div_done;
    sts.reject    = div_reject;
    sts.idx_one   = (idx_r == ADDR_W'(1));
    sts.emit_last = ((LEN_W'(k_r) + LEN_W'(1)) == len_r);
  end

  assign out_byte = rd_a_r;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && len_full |=> len_r == LEN_W'(MAX_LEN))
    else $error("buffer length moved past its maximum");
`endif

endmodule

`default_nettype wire

// File: src/fyse_ctrl.sv
// ----------------------------------------------------------------------------
// Shuffle controller
// State machine sequencing loading, draws, swaps and emission of the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module fyse_ctrl
  import fyse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_mode,
  input  wire logic in_last,
  output      logic in_ready,
  output      logic out_valid,
  input  wire logic out_ready,
  output      cmd_t cmd,
  input  wire sts_t sts
);

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_DRAW     = 3'd1;
  localparam logic [2:0] ST_DIV      = 3'd2;
  localparam logic [2:0] ST_SWAP_WJ  = 3'd3;
  localparam logic [2:0] ST_SWAP_WI  = 3'd4;
  localparam logic [2:0] ST_EMIT_RD  = 3'd5;
  localparam logic [2:0] ST_EMIT_OUT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       in_fire;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire && in_mode == MODE_LOAD) begin
          cmd.load = 1'b1;
          if (in_last) begin
            if (sts.len_zero) begin
              cmd.k_clr = 1'b1;
              state_nxt = ST_EMIT_RD;
            end else begin
              cmd.idx_set = 1'b1;
              state_nxt   = ST_DRAW;
            end
          end
        end
      end
      ST_DRAW: begin
        in_ready = 1'b1;
        if (in_fire && in_mode == MODE_RAND) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          if (sts.reject) begin
            state_nxt = ST_DRAW;
          end else begin
            cmd.swap_rd = 1'b1;
            state_nxt   = ST_SWAP_WJ;
          end
        end
      end
      ST_SWAP_WJ: begin
        cmd.wr_j  = 1'b1;
        state_nxt = ST_SWAP_WI;
      end
      ST_SWAP_WI: begin
        cmd.wr_idx = 1'b1;
        if (sts.idx_one) begin
          cmd.k_clr = 1'b1;
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_DRAW;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.len_clr = 1'b1;
            state_nxt   = ST_LOAD;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && sts.emit_last |=> in_ready && !out_valid)
    else $error("engine did not return to loading after the last byte");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !in_ready ##1 !out_valid)
    else $error("channel activity during a draw");
`endif

endmodule

`default_nettype wire

// File: src/fisher_yates_shuffle_engine_unit.sv
// ----------------------------------------------------------------------------
// Fisher-Yates shuffle engine
// Loads a buffer of bytes, shuffles it with supplied random words and emits it.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries either a data byte (mode 0) or a random word
//   (mode 1). Bytes are appended to the buffer until one arrives with
//   last_element set; bytes beyond MAX_LEN are dropped. The engine then takes
//   one random word per draw, counting the swap index down to 1. Random words
//   during loading and data bytes during shuffling are consumed and ignored.
//   A word that would bias the draw is consumed with no effect. Each accepted
//   random word is taken in and reduced in the bit-serial remainder unit;
//   then both swap entries are read together and written back one after the
//   other through the single buffer write port. After the final draw the
//   buffer is emitted in order, each byte read from the buffer into the output
//   register, the last one flagged with out_last. A single loaded byte is
//   emitted at once. A stalled receiver holds the output byte; no input is
//   taken while the buffer is emitted. Reset returns the engine to loading
//   with an empty buffer; the buffer contents themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fisher_yates_shuffle_engine_unit
  import fyse_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fyse_in_if.sink    in_ch,
  fyse_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  fyse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_last   (in_ch.last_element),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fyse_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .data_byte (in_ch.data_byte),
    .rand_word (in_ch.rand_word),
    .out_byte  (out_ch.out_byte)
  );

  assign out_ch.out_last = sts.emit_last;

endmodule

`default_nettype wire
